[hw/rtl/aprms_pkg.sv]
`default_nettype none
package aprms_pkg;
    localparam int unsigned MaxPairsDefault = 65536;
    localparam int unsigned CountWidth = 17;
    localparam int unsigned NumRegs = 6;
    localparam int unsigned CfgIdxWidth = 3;

    typedef enum logic [2:0] {
        IDX_LIN_00_01      = 3'd0,
        IDX_LIN_02_TRANS_X = 3'd1,
        IDX_LIN_10_11      = 3'd2,
        IDX_LIN_12_TRANS_Y = 3'd3,
        IDX_LIN_20_21      = 3'd4,
        IDX_LIN_22_TRANS_Z = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_ACCUM,
        ST_DIVIDE,
        ST_ROOT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic load;
        logic axis_step;
        logic accum;
        logic div_start;
        logic div_step;
        logic root_start;
        logic root_step;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic axis_done;
        logic div_done;
        logic root_done;
        logic last;
    } status_t;
endpackage
`default_nettype wire

[hw/rtl/affine_point_rms_error_unit.sv]
`default_nettype none
// Each pair runs 3 axes x 4 mapping/square steps, then an accumulate;
// a last pair adds a restoring divide of the sum by the count and a square root.
// New pairs are accepted only in idle; one mapping multiplier serves all axes and terms.
// Reset: aresetn synchronous active low; clears sum, count, flag and
// restores the configuration registers to their defaults.
module affine_point_rms_error_unit import aprms_pkg::*; #(
    parameter int unsigned MAX_PAIRS = MaxPairsDefault
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [191:0]           s_tdata, // fixed_x,y,z, moving_x,y,z
    input  wire logic                   s_tlast, // last_pair
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [55:0]                 m_tdata, // rms_error, pair_count, overflow, pad
    input  wire logic                   cfg_we,
    input  wire logic [CfgIdxWidth-1:0] cfg_idx,
    input  wire logic [63:0]            cfg_data
);
    cmd_t cmd;
    status_t stat;
    logic load;
    logic [31:0] rms;
    logic [CountWidth-1:0] count;
    logic ovf;
    logic out_free;

    assign out_free = !m_tvalid || m_tready;

    aprms_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_tvalid && s_tready),
        .out_free(out_free), .stat(stat), .s_ready(s_tready),
        .result_load(load), .cmd(cmd)
    );

    aprms_dp #(.MAX_PAIRS(MAX_PAIRS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_data(s_tdata),
        .in_last(s_tlast), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .stat(stat), .rms(rms), .count(count), .ovf(ovf)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid <= 1'b1;
                m_tdata <= {6'd0, ovf, count, rms};
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[hw/rtl/aprms_ctrl.sv]
`default_nettype none
module aprms_ctrl import aprms_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_fire,
    input  wire logic    out_free,
    input  wire status_t stat,
    output logic         s_ready,
    output logic         result_load,
    output cmd_t         cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS: begin
                cmd.axis_step = 1'b1;
                if (stat.axis_done) state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum = 1'b1;
                if (stat.last) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    cmd.root_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (stat.root_done) state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    result_load = 1'b1;
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/aprms_dp.sv]
`default_nettype none
module aprms_dp import aprms_pkg::*; #(
    parameter int unsigned MAX_PAIRS = MaxPairsDefault
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    input  wire logic [191:0]          in_data,
    input  wire logic                  in_last,
    input  wire logic                  cfg_we,
    input  wire logic [CfgIdxWidth-1:0] cfg_idx,
    input  wire logic [63:0]           cfg_data,
    output status_t                    stat,
    output logic [31:0]                rms,
    output logic [CountWidth-1:0]      count,
    output logic                       ovf
);
    localparam int unsigned CapInt = (MAX_PAIRS < 131071) ? MAX_PAIRS : 131071;
    localparam logic [CountWidth-1:0] Cap = CountWidth'(CapInt);

    logic [63:0] regs_reg [NumRegs];
    logic signed [31:0] fix_reg [3];
    logic signed [31:0] mov_reg [3];
    logic last_reg;
    logic [1:0] axis_reg;
    logic [1:0] term_reg;
    logic signed [40:0] map_reg;
    logic [63:0] sq_reg;
    logic [63:0] sum_reg;
    logic [CountWidth-1:0] cnt_reg;
    logic ovf_reg;
    logic [63:0] rem_reg, quo_reg;
    logic [6:0] dcnt_reg;
    logic [63:0] rv_reg, res_reg, bit_reg;

    logic [63:0] row_a, row_b;
    logic signed [31:0] coef;
    logic signed [31:0] pt;
    logic signed [63:0] prod;
    logic signed [40:0] term;
    logic signed [41:0] diff;
    logic signed [31:0] dsat;
    logic dovf;
    logic [31:0] dabs;
    logic [64:0] sq_sum;
    logic [64:0] acc;
    logic [64:0] rtrial;

    always_comb begin
        row_a = regs_reg[{axis_reg, 1'b0}];
        row_b = regs_reg[{axis_reg, 1'b1}];
        case (term_reg)
            2'd0: begin coef = row_a[31:0];  pt = mov_reg[0]; end
            2'd1: begin coef = row_a[63:32]; pt = mov_reg[1]; end
            default: begin coef = row_b[31:0]; pt = mov_reg[2]; end
        endcase
        prod = coef * pt;
        term = 41'(prod >>> 24);
        diff = 42'(fix_reg[axis_reg]) - 42'(map_reg);
        dovf = (diff > 42'sh7FFFFFFF) || (diff < -42'sh80000000);
        if (diff > 42'sh7FFFFFFF) dsat = 32'sh7FFFFFFF;
        else if (diff < -42'sh80000000) dsat = 32'sh80000000;
        else dsat = diff[31:0];
        dabs = dsat[31] ? 32'(-33'(dsat)) : dsat;
        sq_sum = {1'b0, sq_reg} + {1'b0, 32'd0, dabs} * {33'd0, dabs};
        acc = {1'b0, sum_reg} + {1'b0, sq_reg};
        rtrial = {1'b0, res_reg} + {1'b0, bit_reg};
    end

    logic [64:0] dshift;
    logic q_bit;
    logic [63:0] quo_next;
    assign dshift = {rem_reg, quo_reg[63]};
    assign q_bit = dshift >= {48'd0, cnt_reg};
    assign quo_next = {quo_reg[62:0], q_bit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[0] <= 64'd16777216;
            regs_reg[1] <= '0;
            regs_reg[2] <= 64'd72057594037927936;
            regs_reg[3] <= '0;
            regs_reg[4] <= '0;
            regs_reg[5] <= 64'd16777216;
            sum_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            axis_reg <= '0;
            term_reg <= '0;
        end else begin
            if (cfg_we && (32'(cfg_idx) < NumRegs)) regs_reg[cfg_idx] <= cfg_data;
            if (cmd.load) begin
                for (int i = 0; i < 3; i++) begin
                    fix_reg[i] <= in_data[32*i +: 32];
                    mov_reg[i] <= in_data[96 + 32*i +: 32];
                end
                last_reg <= in_last;
                axis_reg <= '0;
                term_reg <= '0;
                map_reg <= '0;
                sq_reg <= '0;
            end
            if (cmd.axis_step) begin
                if (term_reg == 2'd3) begin
                    map_reg <= 41'(row_b[63:32]);
                    sq_reg <= sq_sum[63:0];
                    if (dovf) ovf_reg <= 1'b1;
                    term_reg <= '0;
                    axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                end else begin
                    if (term_reg == 2'd0) map_reg <= term + 41'(signed'(row_b[63:32]));
                    else map_reg <= map_reg + term;
                    term_reg <= term_reg + 2'd1;
                end
            end
            if (cmd.accum) begin
                sum_reg <= acc[64] ? '1 : acc[63:0];
                if (cnt_reg < Cap) cnt_reg <= cnt_reg + 1'b1;
                if (acc[64] || (cnt_reg >= Cap)) ovf_reg <= 1'b1;
            end
            if (cmd.div_start) begin
                rem_reg <= '0;
                quo_reg <= acc[64] ? '1 : acc[63:0];
                dcnt_reg <= '0;
            end
            if (cmd.div_step) begin
                if (q_bit) rem_reg <= 64'(dshift - {48'd0, cnt_reg});
                else rem_reg <= dshift[63:0];
                quo_reg <= quo_next;
                dcnt_reg <= dcnt_reg + 7'd1;
            end
            if (cmd.root_start) begin
                rv_reg <= quo_next;
                res_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            if (cmd.root_step) begin
                if ({1'b0, rv_reg} >= rtrial) begin
                    rv_reg <= 64'({1'b0, rv_reg} - rtrial);
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            if (cmd.clear) begin
                sum_reg <= '0;
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    assign stat.axis_done = (axis_reg == 2'd2) && (term_reg == 2'd3);
    assign stat.div_done = (dcnt_reg == 7'd63);
    assign stat.root_done = (bit_reg == 64'd1);
    assign stat.last = last_reg;
    assign rms = res_reg[31:0];
    assign count = cnt_reg;
    assign ovf = ovf_reg;
endmodule
`default_nettype wire

[test/tb_affine_point_rms_error_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_affine_point_rms_error_unit import aprms_pkg::*;;

    typedef struct packed {
        logic [31:0] fixed_x;
        logic [31:0] fixed_y;
        logic [31:0] fixed_z;
        logic [31:0] moving_x;
        logic [31:0] moving_y;
        logic [31:0] moving_z;
        logic        last_pair;
    } pair_t;

    typedef struct packed {
        logic        overflow;
        logic [16:0] pair_count;
        logic [31:0] rms_error;
    } rms_t;

    localparam int unsigned CountCap = (MaxPairsDefault < 131071) ? MaxPairsDefault : 131071;
    localparam int unsigned StallLimit = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_idx = '0;
    logic [63:0]  cfg_data = '0;

    affine_point_rms_error_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    logic [63:0] xform_regs [NumRegs];
    logic [63:0] sum_acc;
    int unsigned pairs_acc;
    bit          ovf_acc;

    pair_t pending_pairs [$];
    rms_t  expected_rms [$];
    int    error_count = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_req = 1'b0;
    bit    hold_used = 1'b0;
    int    hold_off = 0;
    int    quiet_cycles = 0;

    function automatic logic signed [63:0] mapped_term(logic [31:0] coef, logic [31:0] p);
        logic signed [63:0] prod;
        prod = 64'(signed'(coef)) * 64'(signed'(p));
        return prod >>> 24;
    endfunction

    function automatic logic [63:0] axis_sq(logic [63:0] ra, logic [63:0] rb,
                                            pair_t it, logic [31:0] f);
        logic signed [63:0] m, d;
        logic [63:0] a;
        m = mapped_term(ra[31:0], it.moving_x) + mapped_term(ra[63:32], it.moving_y)
          + mapped_term(rb[31:0], it.moving_z) + 64'(signed'(rb[63:32]));
        d = 64'(signed'(f)) - m;
        if (d > 64'sh7FFFFFFF) begin
            d = 64'sh7FFFFFFF;
            ovf_acc = 1'b1;
        end else if (d < -64'sh80000000) begin
            d = -64'sh80000000;
            ovf_acc = 1'b1;
        end
        a = (d < 0) ? -d : d;
        return a * a;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_rms(pair_t it);
        logic [63:0] sq;
        rms_t r;
        sq = axis_sq(xform_regs[IDX_LIN_00_01], xform_regs[IDX_LIN_02_TRANS_X], it, it.fixed_x)
           + axis_sq(xform_regs[IDX_LIN_10_11], xform_regs[IDX_LIN_12_TRANS_Y], it, it.fixed_y)
           + axis_sq(xform_regs[IDX_LIN_20_21], xform_regs[IDX_LIN_22_TRANS_Z], it, it.fixed_z);
        if (sum_acc > ~64'd0 - sq) begin
            sum_acc = ~64'd0;
            ovf_acc = 1'b1;
        end else begin
            sum_acc += sq;
        end
        if (pairs_acc < CountCap) pairs_acc++;
        else ovf_acc = 1'b1;
        if (it.last_pair) begin
            r.rms_error = 32'(int_sqrt(sum_acc / pairs_acc));
            r.pair_count = 17'(pairs_acc);
            r.overflow = ovf_acc;
            expected_rms.push_back(r);
            sum_acc = 0;
            pairs_acc = 0;
            ovf_acc = 0;
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        xform_regs[idx] = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_rms.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(int sel);
        case (sel)
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
        endcase
    endfunction

    function automatic pair_t rand_pair(bit last, int sel);
        pair_t p;
        p.moving_x = rand_coord(sel);
        p.moving_y = rand_coord(sel);
        p.moving_z = rand_coord(sel);
        p.fixed_x = ($urandom_range(0, 3) == 0) ? rand_coord(sel) : p.moving_x + rand_coord(2);
        p.fixed_y = ($urandom_range(0, 3) == 0) ? rand_coord(sel) : p.moving_y + rand_coord(2);
        p.fixed_z = ($urandom_range(0, 3) == 0) ? rand_coord(sel) : p.moving_z + rand_coord(2);
        p.last_pair = last;
        return p;
    endfunction

    task automatic queue_sets(int n_pairs);
        int left, len;
        left = n_pairs;
        while (left > 0) begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0) len = $urandom_range(20, 60);
            if (len > left) len = left;
            for (int k = 0; k < len; k++) begin
                pending_pairs.push_back(rand_pair(k == len - 1,
                    ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : 3));
            end
            left -= len;
        end
    endtask

    function automatic logic [63:0] rand_row(bit ident_low, bit ident_high);
        logic [31:0] lo, hi;
        lo = ident_low ? 32'h0100_0000 + $urandom_range(0, 4095) - 2048 : $urandom_range(0, 1 << 20) - (1 << 19);
        hi = ident_high ? 32'h0100_0000 + $urandom_range(0, 4095) - 2048 : $urandom_range(0, 1 << 20) - (1 << 19);
        return {hi, lo};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_rms(pending_pairs.pop_front());
            end
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_pairs[0].moving_z, pending_pairs[0].moving_y,
                            pending_pairs[0].moving_x, pending_pairs[0].fixed_z,
                            pending_pairs[0].fixed_y, pending_pairs[0].fixed_x};
                s_tlast <= pending_pairs[0].last_pair;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_off <= 3000;
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        rms_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[49:0];
            if (expected_rms.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
            end else begin
                want = expected_rms.pop_front();
                if (got.rms_error !== want.rms_error)
                    report_mismatch("rms_error", 64'(got.rms_error), 64'(want.rms_error));
                if (got.pair_count !== want.pair_count)
                    report_mismatch("pair_count", 64'(got.pair_count), 64'(want.pair_count));
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("affine_point_rms_error_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        xform_regs[0] = 64'd16777216;
        xform_regs[1] = '0;
        xform_regs[2] = 64'd72057594037927936;
        xform_regs[3] = '0;
        xform_regs[4] = '0;
        xform_regs[5] = 64'd16777216;
        sum_acc = 0;
        pairs_acc = 0;
        ovf_acc = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity map, zeros, extremes, single-pair and multi-pair sets
        pending_pairs.push_back('{0, 0, 0, 0, 0, 0, 1'b1});
        pending_pairs.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h80000000, 32'h80000000, 32'h80000000, 1'b1});
        pending_pairs.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                  32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0});
        pending_pairs.push_back('{32'h00010000, 32'hFFFF0000, 0, 0, 0, 0, 1'b1});
        pending_pairs.push_back('{32'h00030000, 32'h00040000, 0, 0, 0, 0, 1'b0});
        pending_pairs.push_back('{32'hFFFFFFFF, 32'h00000001, 32'h55555555,
                                  32'hAAAAAAAA, 32'h0000FFFF, 32'hFFFF0000, 1'b1});
        for (int k = 0; k < 6; k++) pending_pairs.push_back(rand_pair(k == 5, 3));
        wait_drained();

        // directed: extreme coefficients
        write_reg(IDX_LIN_00_01, {32'h80000000, 32'h7FFFFFFF});
        write_reg(IDX_LIN_02_TRANS_X, {32'h7FFFFFFF, 32'h80000000});
        write_reg(IDX_LIN_10_11, {32'hFFFFFFFF, 32'h80000000});
        write_reg(IDX_LIN_12_TRANS_Y, {32'h80000000, 32'hFFFFFFFF});
        write_reg(IDX_LIN_20_21, {32'h7FFFFFFF, 32'h7FFFFFFF});
        write_reg(IDX_LIN_22_TRANS_Z, {32'h7FFFFFFF, 32'h80000000});
        for (int k = 0; k < 8; k++) pending_pairs.push_back(rand_pair(k % 3 == 2 || k == 7, k % 4));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(IDX_LIN_00_01, rand_row(1, 0));
            write_reg(IDX_LIN_02_TRANS_X, {$urandom, 32'($urandom_range(0, 1 << 20)) - (1 << 19)});
            write_reg(IDX_LIN_10_11, rand_row(0, 1));
            write_reg(IDX_LIN_12_TRANS_Y, {$urandom, 32'($urandom_range(0, 1 << 20)) - (1 << 19)});
            write_reg(IDX_LIN_20_21, (ph == 3) ? {$urandom, $urandom} : rand_row(0, 0));
            write_reg(IDX_LIN_22_TRANS_Z, {$urandom, 32'h0100_0000});
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (ph == 2) hold_req = 1'b1;
            queue_sets(120);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("affine_point_rms_error_unit regression: pass");
        end else begin
            $display("affine_point_rms_error_unit regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

[affine_point_rms_error_unit.f]
hw/rtl/aprms_pkg.sv
hw/rtl/aprms_ctrl.sv
hw/rtl/aprms_dp.sv
hw/rtl/affine_point_rms_error_unit.sv
test/tb_affine_point_rms_error_unit.sv
